>>> hw/rtl/mcfir_pkg.sv
package mcfir_pkg;

  localparam int CHAN_W     = 3;
  localparam int COEF_IDX_W = 8;
  localparam int CFG_W      = 9;
  localparam int ACC_W      = 64;

  localparam int DEFAULT_TAPS = 191;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_COEF   = 1'b1;

endpackage

>>> hw/rtl/mcfir_ram.sv
module mcfir_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/multichannel_fir_filter.sv
// Sample item: the result is rounded and loaded into the output register, which waits while
// out_ready stalls; only then is the next item taken. Coefficient loads keep in_ready high.
// The sample rate is set by the single shared multiply-accumulate, one tap per cycle.
// rst_n is synchronous, active low. After reset a clearing pass over all
// MAX_CHANNELS * 2**clog2(MAX_TAPS) history entries (2048 by default) zeroes both memories;
// in_ready stays low meanwhile, configuration writes are taken throughout.
module multichannel_fir_filter #(
  parameter int MAX_TAPS     = 256,
  parameter int MAX_CHANNELS = 8,
  parameter int SAMPLE_BITS  = 16,
  parameter int COEF_BITS    = 24
) (
  input  logic                               clk,
  input  logic                               rst_n,

  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mcfir_pkg::CFG_W-1:0]        cfg_num_taps,

  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_opcode,
  input  logic [mcfir_pkg::CHAN_W-1:0]       in_channel,
  input  logic signed [SAMPLE_BITS-1:0]      in_sample_in,
  input  logic [mcfir_pkg::COEF_IDX_W-1:0]   in_coef_index,
  input  logic signed [COEF_BITS-1:0]        in_coef_value,

  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [mcfir_pkg::CHAN_W-1:0]       out_channel,
  output logic signed [SAMPLE_BITS-1:0]      out_sample_out,
  output logic                               out_clipped
);

  import mcfir_pkg::*;

  localparam int TAP_AW     = $clog2(MAX_TAPS);
  localparam int TAP_CW     = $clog2(MAX_TAPS + 1);
  localparam int CH_AW      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int HIST_DEPTH = MAX_CHANNELS * (2 ** TAP_AW);
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int PROD_W     = SAMPLE_BITS + COEF_BITS;
  localparam int RESET_TAPS = (DEFAULT_TAPS > MAX_TAPS) ? MAX_TAPS : DEFAULT_TAPS;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] RND_ADD = ACC_W'(1) << (COEF_BITS - 2);
  localparam logic signed [ACC_W-1:0] SMAX    = (ACC_W'(1) << (SAMPLE_BITS - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] SMIN    = -SMAX - ACC_W'(1);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_MAC, S_ROUND, S_DONE} state_t;

  function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                      input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W-1:0] s;
    s = a + b;
    if (!a[ACC_W-1] && !b[ACC_W-1] && s[ACC_W-1]) begin
      return ACC_MAX;
    end else if (a[ACC_W-1] && b[ACC_W-1] && !s[ACC_W-1]) begin
      return ACC_MIN;
    end
    return s;
  endfunction

  function automatic logic [TAP_CW-1:0] clamp_taps(input logic [CFG_W-1:0] v);
    if (v == '0) begin
      return TAP_CW'(1);
    end else if (32'(v) > 32'(MAX_TAPS)) begin
      return TAP_CW'(MAX_TAPS);
    end
    return TAP_CW'(v);
  endfunction

  state_t                    state_r;
  logic [HIST_AW-1:0]        clr_cnt_r;
  logic [TAP_CW-1:0]         taps_r;
  logic [TAP_AW-1:0]         hptr_r [MAX_CHANNELS];
  logic [TAP_CW-1:0]         m_r;
  logic [TAP_AW-1:0]         idx_r;
  logic [CHAN_W-1:0]         chan_r;
  logic                      rd_v_r;
  logic                      prod_v_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic                      out_valid_r;
  logic [CHAN_W-1:0]         out_channel_r;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;
  logic                      out_clip_r;

  logic                      in_acc;
  logic                      smp_ok;
  logic                      coef_ok;
  logic [CH_AW-1:0]          in_ch;
  logic [CH_AW-1:0]          cur_ch;
  logic [TAP_AW-1:0]         in_ptr;
  logic                      issue;
  logic                      out_load;

  logic                      coef_we;
  logic [TAP_AW-1:0]         coef_waddr;
  logic [COEF_BITS-1:0]      coef_wdata;
  logic [COEF_BITS-1:0]      coef_rdata;
  logic                      hist_we;
  logic [HIST_AW-1:0]        hist_waddr;
  logic [SAMPLE_BITS-1:0]    hist_wdata;
  logic [SAMPLE_BITS-1:0]    hist_rdata;

  logic signed [ACC_W-1:0]   add_b;
  logic signed [ACC_W-1:0]   shifted;
  logic signed [SAMPLE_BITS-1:0] res_val;
  logic                      res_clip;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign in_ch     = CH_AW'(in_channel);
  assign cur_ch    = CH_AW'(chan_r);
  assign in_ptr    = hptr_r[in_ch];
  assign smp_ok    = in_acc && (in_opcode == OP_SAMPLE) && (32'(in_channel) < 32'(MAX_CHANNELS));
  assign coef_ok   = in_acc && (in_opcode == OP_COEF) && (32'(in_coef_index) < 32'(MAX_TAPS));
  assign issue     = (state_r == S_MAC) && (m_r < taps_r);
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    if (state_r == S_CLEAR) begin
      coef_we    = 32'(clr_cnt_r) < 32'(MAX_TAPS);
      coef_waddr = TAP_AW'(clr_cnt_r);
      coef_wdata = '0;
      hist_we    = 1'b1;
      hist_waddr = clr_cnt_r;
      hist_wdata = '0;
    end else begin
      coef_we    = coef_ok;
      coef_waddr = TAP_AW'(in_coef_index);
      coef_wdata = in_coef_value;
      hist_we    = smp_ok;
      hist_waddr = HIST_AW'({in_ch, in_ptr});
      hist_wdata = in_sample_in;
    end
  end

  mcfir_ram #(.WIDTH(COEF_BITS), .DEPTH(MAX_TAPS)) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (coef_wdata),
    .raddr (m_r[TAP_AW-1:0]),
    .rdata (coef_rdata)
  );

  mcfir_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(HIST_DEPTH)) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .raddr (HIST_AW'({cur_ch, idx_r})),
    .rdata (hist_rdata)
  );

  // shared accumulate adder: product during MAC, rounding constant afterwards
  assign add_b   = (state_r == S_ROUND) ? RND_ADD
                                        : {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
  assign shifted = acc_r >>> (COEF_BITS - 1);

  always_comb begin
    if (shifted > SMAX) begin
      res_val  = SAMPLE_BITS'(SMAX);
      res_clip = 1'b1;
    end else if (shifted < SMIN) begin
      res_val  = SAMPLE_BITS'(SMIN);
      res_clip = 1'b1;
    end else begin
      res_val  = SAMPLE_BITS'(shifted);
      res_clip = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      taps_r      <= TAP_CW'(RESET_TAPS);
      m_r         <= '0;
      rd_v_r      <= 1'b0;
      prod_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        hptr_r[c] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        taps_r <= clamp_taps(cfg_num_taps);
      end
      rd_v_r   <= issue;
      prod_v_r <= rd_v_r;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (32'(clr_cnt_r) == 32'(HIST_DEPTH - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (smp_ok) begin
            hptr_r[in_ch] <= (32'(in_ptr) == 32'(MAX_TAPS - 1)) ? '0 : in_ptr + 1'b1;
            m_r           <= '0;
            state_r       <= S_MAC;
          end
        end
        S_MAC: begin
          if (issue) begin
            m_r <= m_r + 1'b1;
          end else if (!rd_v_r && !prod_v_r) begin
            state_r <= S_ROUND;
          end
        end
        S_ROUND: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (smp_ok) begin
      idx_r  <= in_ptr;
      chan_r <= in_channel;
      acc_r  <= '0;
    end else begin
      if (issue) begin
        idx_r <= (idx_r == '0) ? TAP_AW'(MAX_TAPS - 1) : idx_r - 1'b1;
      end
      if (prod_v_r || state_r == S_ROUND) begin
        acc_r <= sat_add(acc_r, add_b);
      end
    end
    if (rd_v_r) begin
      prod_r <= $signed(hist_rdata) * $signed(coef_rdata);
    end
    if (out_load) begin
      out_channel_r <= chan_r;
      out_sample_r  <= res_val;
      out_clip_r    <= res_clip;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_channel    = out_channel_r;
  assign out_sample_out = out_sample_r;
  assign out_clipped    = out_clip_r;

endmodule

>>> hw/rtl/mcfir_checker.sv
module mcfir_checker #(
  parameter int MAX_CHANNELS = 8,
  parameter int SAMPLE_BITS  = 16
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               in_opcode,
  input logic [mcfir_pkg::CHAN_W-1:0]       in_channel,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [mcfir_pkg::CHAN_W-1:0]       out_channel,
  input logic signed [SAMPLE_BITS-1:0]      out_sample_out,
  input logic                               out_clipped
);

  import mcfir_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_channel) && $stable(out_sample_out)
      && $stable(out_clipped))
    else $error("result changed while stalled");

  a_busy_after_sample: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_opcode == OP_SAMPLE && 32'(in_channel) < 32'(MAX_CHANNELS)
      |=> !in_ready)
    else $error("ready after accepting a sample");

  a_coef_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_opcode == OP_COEF |=> in_ready)
    else $error("coefficient load did not complete in one cycle");

  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a sample in work");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("outputs active after reset");

endmodule

bind multichannel_fir_filter mcfir_checker #(
  .MAX_CHANNELS (MAX_CHANNELS),
  .SAMPLE_BITS  (SAMPLE_BITS)
) u_mcfir_checker (.*);

>>> verif/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mcfir_pkg::*;

  localparam int TAPS_MAX = 256;
  localparam int CHANS    = 8;
  localparam int SMP_W    = 16;
  localparam int COEF_W   = 24;
  localparam longint SMP_MAX = (longint'(1) << (SMP_W - 1)) - 1;
  localparam longint SMP_MIN = -SMP_MAX - 1;
  localparam int SETTLE   = TAPS_MAX + 40;
  localparam int WATCHDOG = 20000;
  localparam int N_PHASES = 14;
  localparam int PHASE_ITEMS = 138;
  localparam int N_DIRECTED  = 22;
  localparam logic [CFG_W-1:0] TAP_PLAN [N_PHASES] = '{
    9'd0, 9'd1, 9'd511, 9'd2, 9'd256, 9'd257, 9'd5,
    9'd64, 9'd1, 9'd191, 9'd33, 9'd300, 9'd3, 9'd128
  };

  typedef struct packed {
    logic                     op;
    logic [CHAN_W-1:0]        chan;
    logic signed [SMP_W-1:0]  smp;
    logic [COEF_IDX_W-1:0]    cidx;
    logic signed [COEF_W-1:0] cval;
    logic                     typed;
    logic signed [SMP_W-1:0]  want;
    logic                     want_clip;
  } stim_t;

  typedef struct packed {
    logic [CHAN_W-1:0]       chan;
    logic signed [SMP_W-1:0] value;
    logic                    clip;
  } filt_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_num_taps = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_opcode = OP_SAMPLE;
  logic [CHAN_W-1:0] in_channel = '0;
  logic signed [SMP_W-1:0] in_sample_in = '0;
  logic [COEF_IDX_W-1:0] in_coef_index = '0;
  logic signed [COEF_W-1:0] in_coef_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [CHAN_W-1:0] out_channel;
  logic signed [SMP_W-1:0] out_sample_out;
  logic out_clipped;

  // filter state mirror
  logic signed [COEF_W-1:0] coef_mem [TAPS_MAX];
  logic signed [SMP_W-1:0]  hist [CHANS][TAPS_MAX];
  logic [7:0]               wr_ptr [CHANS];
  int unsigned              tap_count;

  filt_result_t pending_results [$];
  filt_result_t seen, want;
  int  err_count = 0;
  int  stall_left = 0;
  int  idle_cycles = 0;
  bit  no_idle = 1'b0;

  stim_t directed_tbl [N_DIRECTED] = '{
    '{OP_SAMPLE, 3'd0, 16'sh7FFF, 8'd0,   24'sh000000, 1'b1, 16'sh0000, 1'b0},
    '{OP_SAMPLE, 3'd7, 16'sh8000, 8'd255, 24'sh7FFFFF, 1'b1, 16'sh0000, 1'b0},
    '{OP_COEF,   3'd5, 16'sh1234, 8'd255, 24'sh7FFFFF, 1'b0, 16'sh0000, 1'b0},
    '{OP_COEF,   3'd2, 16'sh0000, 8'd0,   24'sh7FFFFF, 1'b0, 16'sh0000, 1'b0},
    '{OP_SAMPLE, 3'd1, 16'sh7FFF, 8'd0,   24'sh000000, 1'b1, 16'sh7FFF, 1'b0},
    '{OP_SAMPLE, 3'd1, 16'sh8000, 8'd0,   24'sh000000, 1'b1, 16'sh8000, 1'b0},
    '{OP_COEF,   3'd0, 16'sh0000, 8'd0,   24'sh800000, 1'b0, 16'sh0000, 1'b0},
    '{OP_SAMPLE, 3'd3, 16'sh8000, 8'd0,   24'sh000000, 1'b1, 16'sh7FFF, 1'b1},
    '{OP_SAMPLE, 3'd4, 16'sh7FFF, 8'd0,   24'sh000000, 1'b1, 16'sh8001, 1'b0},
    '{OP_COEF,   3'd0, 16'sh0000, 8'd1,   24'sh800000, 1'b0, 16'sh0000, 1'b0},
    '{OP_SAMPLE, 3'd4, 16'sh7FFF, 8'd0,   24'sh000000, 1'b1, 16'sh8000, 1'b1},
    '{OP_COEF,   3'd0, 16'sh0000, 8'd0,   24'sh400000, 1'b0, 16'sh0000, 1'b0},
    '{OP_SAMPLE, 3'd5, 16'sh0001, 8'd0,   24'sh000000, 1'b1, 16'sh0001, 1'b0},
    '{OP_SAMPLE, 3'd6, 16'shFFFF, 8'd0,   24'sh000000, 1'b1, 16'sh0000, 1'b0},
    '{OP_SAMPLE, 3'd5, 16'shFFFF, 8'd0,   24'sh000000, 1'b1, 16'shFFFF, 1'b0},
    '{OP_COEF,   3'd0, 16'sh0000, 8'd2,   24'sh000001, 1'b0, 16'sh0000, 1'b0},
    '{OP_COEF,   3'd0, 16'sh0000, 8'd190, 24'sh2AAAAA, 1'b0, 16'sh0000, 1'b0},
    '{OP_COEF,   3'd0, 16'sh0000, 8'd191, 24'sh555555, 1'b0, 16'sh0000, 1'b0},
    '{OP_SAMPLE, 3'd0, 16'sh5A5A, 8'd0,   24'sh000000, 1'b0, 16'sh0000, 1'b0},
    '{OP_SAMPLE, 3'd2, 16'sh8001, 8'd0,   24'sh000000, 1'b0, 16'sh0000, 1'b0},
    '{OP_SAMPLE, 3'd7, 16'sh0100, 8'd0,   24'sh000000, 1'b0, 16'sh0000, 1'b0},
    '{OP_SAMPLE, 3'd3, 16'sh0000, 8'd0,   24'sh000000, 1'b0, 16'sh0000, 1'b0}
  };

  multichannel_fir_filter #(
    .MAX_TAPS(TAPS_MAX), .MAX_CHANNELS(CHANS), .SAMPLE_BITS(SMP_W), .COEF_BITS(COEF_W)
  ) dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_num_taps(cfg_num_taps),
    .in_valid(in_valid), .in_ready(in_ready), .in_opcode(in_opcode),
    .in_channel(in_channel), .in_sample_in(in_sample_in),
    .in_coef_index(in_coef_index), .in_coef_value(in_coef_value),
    .out_valid(out_valid), .out_ready(out_ready), .out_channel(out_channel),
    .out_sample_out(out_sample_out), .out_clipped(out_clipped)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(21, 300);
  endfunction

  // 256 taps of 24x16 bits cannot reach the 64-bit accumulator limits
  function automatic filt_result_t filter_sample(logic [CHAN_W-1:0] ch,
                                                 logic signed [SMP_W-1:0] s);
    filt_result_t r;
    longint acc;
    longint v;
    logic [7:0] idx;
    hist[ch][wr_ptr[ch]] = s;
    idx = wr_ptr[ch];
    acc = 0;
    for (int m = 0; m < tap_count; m++) begin
      acc += longint'(coef_mem[m]) * longint'(hist[ch][idx]);
      idx--;
    end
    wr_ptr[ch]++;
    acc += longint'(1) << (COEF_W - 2);
    v = acc >>> (COEF_W - 1);
    r.chan = ch;
    r.clip = 1'b0;
    if (v > SMP_MAX) begin
      v = SMP_MAX;
      r.clip = 1'b1;
    end else if (v < SMP_MIN) begin
      v = SMP_MIN;
      r.clip = 1'b1;
    end
    r.value = v[SMP_W-1:0];
    return r;
  endfunction

  function automatic void apply_item(stim_t s);
    filt_result_t r;
    if (s.op == OP_COEF) begin
      coef_mem[s.cidx] = s.cval;
    end else begin
      r = filter_sample(s.chan, s.smp);
      if (s.typed) begin
        r.value = s.want;
        r.clip = s.want_clip;
      end
      pending_results.push_back(r);
    end
  endfunction

  function automatic stim_t rand_item();
    stim_t s;
    s.typed = 1'b0;
    s.want = '0;
    s.want_clip = 1'b0;
    s.chan = CHAN_W'($urandom);
    s.smp = SMP_W'($urandom);
    s.cidx = COEF_IDX_W'($urandom);
    s.cval = COEF_W'($urandom);
    if ($urandom_range(0, 99) < 30) begin
      s.op = OP_COEF;
      if ($urandom_range(0, 99) < 70) s.cidx = COEF_IDX_W'($urandom_range(0, tap_count - 1));
      case ($urandom_range(0, 9))
        0: s.cval = 24'sh7FFFFF;
        1: s.cval = 24'sh800000;
        2: s.cval = '0;
        3, 4, 5, 6: s.cval = s.cval >>> $urandom_range(4, 14);
        default: ;
      endcase
    end else begin
      s.op = OP_SAMPLE;
      case ($urandom_range(0, 9))
        0: s.smp = 16'sh7FFF;
        1: s.smp = 16'sh8000;
        2: s.smp = '0;
        default: ;
      endcase
    end
    return s;
  endfunction

  task automatic send_item(stim_t s);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= s.op;
    in_channel <= s.chan;
    in_sample_in <= s.smp;
    in_coef_index <= s.cidx;
    in_coef_value <= s.cval;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_item(s);
  endtask

  task automatic write_taps(logic [CFG_W-1:0] v);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_num_taps <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (v == 0) tap_count = 1;
    else if (v > TAPS_MAX) tap_count = TAPS_MAX;
    else tap_count = v;
  endtask

  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      seen = '{out_channel, out_sample_out, out_clipped};
      if (pending_results.size() == 0) begin
        err_count++;
        $display("%0t: expected no result, got ch %0d sample %0d clip %0d",
                 $time, seen.chan, seen.value, seen.clip);
      end else begin
        want = pending_results.pop_front();
        if (seen.chan !== want.chan || seen.value !== want.value || seen.clip !== want.clip) begin
          err_count++;
          $display("%0t: expected ch %0d sample %0d clip %0d, got ch %0d sample %0d clip %0d",
                   $time, want.chan, want.value, want.clip,
                   seen.chan, seen.value, seen.clip);
        end
      end
    end
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      stall_left = pick_gap();
      out_ready <= (stall_left == 0);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int t = 0; t < TAPS_MAX; t++) coef_mem[t] = '0;
    for (int c = 0; c < CHANS; c++) begin
      wr_ptr[c] = '0;
      for (int t = 0; t < TAPS_MAX; t++) hist[c][t] = '0;
    end
    tap_count = DEFAULT_TAPS;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed_tbl[i]) send_item(directed_tbl[i]);
    for (int p = 0; p < N_PHASES; p++) begin
      no_idle = (p % 4 == 2);
      write_taps(TAP_PLAN[p]);
      for (int k = 0; k < PHASE_ITEMS; k++) send_item(rand_item());
    end
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (err_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
